FILE: design/spr_pkg.sv
// Shared types and constants for the speed ramp position generator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package spr_pkg;

    localparam int NUM_RANGES_DEF = 5;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int ACCEL_W    = 16;
    localparam int FRAME_W    = 32;
    localparam int COUNT_W    = 3;
    localparam int RANGE_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_FRAMES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_0      = 3'd3;

    typedef struct packed {
        logic [ACCEL_W-1:0] accel_step;
        logic [FRAME_W-1:0] track_frames;
        logic [COUNT_W-1:0] range_count;
    } cfg_scalar_t;

endpackage

FILE: design/spr_cfg_regs.sv
// Configuration register file: accel step, track length, range count, ranges.
// Depends on spr_pkg.
`timescale 1ns / 1ps

module spr_cfg_regs #(
    parameter int NUM_RANGES = spr_pkg::NUM_RANGES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output spr_pkg::cfg_scalar_t             cfg_scalar,
    output logic [spr_pkg::RANGE_W-1:0]      ranges [NUM_RANGES]
);

    spr_pkg::cfg_scalar_t            scalar_reg;
    logic [spr_pkg::RANGE_W-1:0]     range_reg [NUM_RANGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scalar_reg.accel_step   <= '0;
            scalar_reg.track_frames <= '0;
            scalar_reg.range_count  <= spr_pkg::COUNT_W'(1);
            for (int r = 0; r < NUM_RANGES; r++) begin
                range_reg[r] <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                spr_pkg::REG_ACCEL_STEP: begin
                    scalar_reg.accel_step <= cfg_wdata[spr_pkg::ACCEL_W-1:0];
                end
                spr_pkg::REG_TRACK_FRAMES: begin
                    scalar_reg.track_frames <= cfg_wdata[spr_pkg::FRAME_W-1:0];
                end
                spr_pkg::REG_RANGE_COUNT: begin
                    scalar_reg.range_count <= cfg_wdata[spr_pkg::COUNT_W-1:0];
                end
                default: begin
                    for (int r = 0; r < NUM_RANGES; r++) begin
                        if (cfg_index == spr_pkg::CFG_IDX_W'(spr_pkg::REG_RANGE_0 + r)) begin
                            range_reg[r] <= cfg_wdata[spr_pkg::RANGE_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    assign cfg_scalar = scalar_reg;
    assign ranges     = range_reg;

endmodule

FILE: design/spr_step_core.sv
// Playback state (position, speed, range index, peak) and the per-request step.
// Depends on spr_pkg; fed by spr_cfg_regs.
`timescale 1ns / 1ps

module spr_step_core #(
    parameter int NUM_RANGES = spr_pkg::NUM_RANGES_DEF,
    parameter int FRAC_BITS  = spr_pkg::FRAC_BITS_DEF,
    localparam int SPW = 8 + FRAC_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  spr_pkg::cfg_scalar_t             cfg_scalar,
    input  logic [spr_pkg::RANGE_W-1:0]      ranges [NUM_RANGES],
    input  logic                             step_en,
    input  logic                             restart,
    output logic [spr_pkg::FRAME_W-1:0]      res_frame,
    output logic [SPW-1:0]                   res_speed,
    output logic                             res_done
);

    localparam int FW  = FRAC_BITS + 32;
    localparam int PW  = FRAC_BITS + 33;
    localparam int RIW = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
    localparam int CW  = 4;
    localparam int COUNT_W_L = spr_pkg::COUNT_W;
    localparam logic [SPW-1:0] ONE_SPEED = {8'd1, {FRAC_BITS{1'b0}}};
    localparam logic [SPW-1:0] SPD_MAX   = {1'b0, {(SPW-1){1'b1}}};
    localparam logic [SPW-1:0] SPD_MIN   = {1'b1, {(SPW-1){1'b0}}};
    localparam logic [PW-1:0]  POS_MAX   = {1'b0, {(PW-1){1'b1}}};
    localparam logic [PW-1:0]  POS_MIN   = {1'b1, {(PW-1){1'b0}}};

    logic [PW-1:0]   position_reg, position_next;
    logic [SPW-1:0]  speed_reg, speed_next;
    logic [RIW-1:0]  range_index_reg, range_index_next;
    logic [32:0]     peak_reg, peak_next;

    logic [PW-1:0]   pos_e;
    logic [SPW-1:0]  spd_e;
    logic [RIW-1:0]  idx_e;
    logic [32:0]     peak_e;
    logic [FW-1:0]   pos_u;
    logic [SPW-1:0]  acc;
    logic [COUNT_W_L-1:0] count;
    logic [31:0]     cur_start, cur_stop, nxt_start;
    logic [RIW-1:0]  idx_nx;
    logic            done, in_rng, past_stop, has_next, falling;
    logic [SPW:0]    spd_sum;
    logic [SPW-1:0]  spd_sat, spd_new;
    logic [PW:0]     pos_sum;
    logic [PW-1:0]   pos_new;

    if (FRAC_BITS >= 16) begin : g_acc_up
        assign acc = SPW'(cfg_scalar.accel_step) << (FRAC_BITS - 16);
    end else begin : g_acc_dn
        assign acc = SPW'(cfg_scalar.accel_step >> (16 - FRAC_BITS));
    end

    always_comb begin
        if (cfg_scalar.range_count == '0) begin
            count = COUNT_W_L'(1);
        end else if (32'(cfg_scalar.range_count) > NUM_RANGES) begin
            count = COUNT_W_L'(NUM_RANGES);
        end else begin
            count = cfg_scalar.range_count;
        end

        pos_e  = restart ? '0 : position_reg;
        spd_e  = restart ? ONE_SPEED : speed_reg;
        idx_e  = restart ? '0 : range_index_reg;
        peak_e = restart ? {1'b0, ranges[0][31:0]} : peak_reg;
        pos_u  = pos_e[FW-1:0];

        done = pos_e[PW-1] || (pos_u >= {cfg_scalar.track_frames, {FRAC_BITS{1'b0}}});

        cur_start = ranges[idx_e][31:0];
        cur_stop  = ranges[idx_e][63:32];
        idx_nx    = RIW'(idx_e + 1'b1);
        nxt_start = ranges[idx_nx][31:0];
        has_next  = (CW'(idx_e) + CW'(1)) < CW'(count);

        in_rng    = (pos_u >= {cur_start, {FRAC_BITS{1'b0}}})
                 && (pos_u <= {cur_stop, {FRAC_BITS{1'b0}}});
        past_stop = pos_u > {cur_stop, {FRAC_BITS{1'b0}}};

        peak_next        = peak_e;
        range_index_next = idx_e;
        if (!in_rng && past_stop) begin
            if (has_next) begin
                range_index_next = idx_nx;
                peak_next        = 33'(cur_stop) + 33'(nxt_start);
            end else begin
                peak_next = 33'(cur_stop) + 33'(cfg_scalar.track_frames);
            end
        end

        falling = pos_u > {peak_next, {(FRAC_BITS-1){1'b0}}};
        if (falling) begin
            spd_sum = {spd_e[SPW-1], spd_e} - {1'b0, acc};
        end else begin
            spd_sum = {spd_e[SPW-1], spd_e} + {1'b0, acc};
        end
        if (spd_sum[SPW] != spd_sum[SPW-1]) begin
            spd_sat = spd_sum[SPW] ? SPD_MIN : SPD_MAX;
        end else begin
            spd_sat = spd_sum[SPW-1:0];
        end
        spd_new = in_rng ? ONE_SPEED : spd_sat;

        pos_sum = {pos_e[PW-1], pos_e} + {{(PW+1-SPW){spd_new[SPW-1]}}, spd_new};
        if (pos_sum[PW] != pos_sum[PW-1]) begin
            pos_new = pos_sum[PW] ? POS_MIN : POS_MAX;
        end else begin
            pos_new = pos_sum[PW-1:0];
        end

        if (done) begin
            position_next    = pos_e;
            speed_next       = spd_e;
            range_index_next = idx_e;
            peak_next        = peak_e;
            res_frame        = '0;
        end else begin
            position_next = pos_new;
            speed_next    = spd_new;
            res_frame     = pos_u[FW-1:FRAC_BITS];
        end
        res_speed = speed_next;
        res_done  = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg    <= '0;
            speed_reg       <= ONE_SPEED;
            range_index_reg <= '0;
            peak_reg        <= '0;
        end else if (step_en) begin
            position_reg    <= position_next;
            speed_reg       <= speed_next;
            range_index_reg <= range_index_next;
            peak_reg        <= peak_next;
        end
    end

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(range_index_reg) < NUM_RANGES)
        else $error("range index beyond range table");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res_done && !restart |=> $stable(position_reg) && $stable(speed_reg))
        else $error("state moved on a done request");

endmodule

FILE: design/speed_ramp_position_generator_unit.sv
// Top level of the speed ramp position generator: stream ports, output register.
// Depends on spr_pkg, spr_cfg_regs and spr_step_core.
// The result is registered and valid in the cycle after the request is accepted.
// Throughput: one request per cycle unless m_tvalid is held without m_tready;
// the state update loop in spr_step_core (position, speed, range, peak) sets this figure.
// Reset (aresetn low, synchronous): position 0, speed 1.0, range 0, peak 0,
// registers to their reset values, output empty. No clearing pass.
`timescale 1ns / 1ps

module speed_ramp_position_generator_unit #(
    parameter int NUM_RANGES = spr_pkg::NUM_RANGES_DEF,
    parameter int FRAC_BITS  = spr_pkg::FRAC_BITS_DEF,
    localparam int SPW   = 8 + FRAC_BITS,
    localparam int OUT_W = ((spr_pkg::FRAME_W + SPW + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [spr_pkg::IN_W-1:0]         s_tdata,   // [0] restart
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [OUT_W-1:0]                 m_tdata,   // source_frame, current_speed
    output logic                             m_tuser    // [0] done_res
);

    spr_pkg::cfg_scalar_t            cfg_scalar;
    logic [spr_pkg::RANGE_W-1:0]     ranges [NUM_RANGES];
    logic                            s_accept;
    logic [spr_pkg::FRAME_W-1:0]     res_frame;
    logic [SPW-1:0]                  res_speed;
    logic                            res_done;
    logic                            m_tvalid_reg;
    logic [OUT_W-1:0]                m_tdata_reg;
    logic                            m_tuser_reg;

    spr_cfg_regs #(
        .NUM_RANGES (NUM_RANGES)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cfg_scalar (cfg_scalar),
        .ranges     (ranges)
    );

    spr_step_core #(
        .NUM_RANGES (NUM_RANGES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_scalar (cfg_scalar),
        .ranges     (ranges),
        .step_en    (s_accept),
        .restart    (s_tdata[0]),
        .res_frame  (res_frame),
        .res_speed  (res_speed),
        .res_done   (res_done)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= OUT_W'({res_speed, res_frame});
            m_tuser_reg <= res_done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted request produced no result");

    a_done_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[spr_pkg::FRAME_W-1:0] == '0)
        else $error("done result carries a nonzero frame");

endmodule
